// ===== rtl/core/tglc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tglc_pkg: shared types and constants for the text glyph layout and clip
// Glyph geometry, atlas layout, character codes and the glyph job carried
// from the front end to the clip back end.
// ----------------------------------------------------------------------------
package tglc_pkg;

  // Glyph geometry and atlas placement
  localparam int GLYPH_W        = 8;
  localparam int GLYPH_H        = 12;
  localparam int ATLAS_ORIGIN_X = 0;
  localparam int ATLAS_COLS     = 13;
  localparam int CHAR_GAP       = 1;
  localparam int LINE_GAP       = 3;

  // Row of a glyph index: floor(idx * 79 / 1024) equals idx / 13 for idx < 95
  localparam int ROW_RECIP = 79;
  localparam int ROW_SHIFT = 10;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHAR_TAB         = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE     = 8'd10;
  localparam logic [7:0] CHAR_CR          = 8'd13;
  localparam logic [7:0] CHAR_SPACE       = 8'd32;
  localparam logic [7:0] CHAR_FIRST_GLYPH = 8'd33;
  localparam logic [7:0] CHAR_LAST_GLYPH  = 8'd127;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_CHAR  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ANCHOR_LEFT   = 2'd0,
    ANCHOR_CENTRE = 2'd1,
    ANCHOR_RIGHT  = 2'd2
  } anchor_e;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_WIDTH  = 2'd2,
    REG_CLIP_HEIGHT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic [3:0]         col;
    logic [2:0]         row;
  } job_t;

  // Saturate an 18-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tglc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tglc_queue: glyph job queue
// Short flip-flop queue that decouples the layout front end from the clip
// back end.
// ----------------------------------------------------------------------------
module tglc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire tglc_pkg::job_t wr_job_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output tglc_pkg::job_t      rd_job_o,
  output logic                empty_o
);

  tglc_pkg::job_t                    slot_q [tglc_pkg::QUEUE_DEPTH];
  logic [tglc_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [tglc_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [tglc_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                              do_wr, do_rd;

  assign full_o   = (count_q == tglc_pkg::QCNT_W'(tglc_pkg::QUEUE_DEPTH));
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == tglc_pkg::QPTR_W'(tglc_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == tglc_pkg::QPTR_W'(tglc_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_job_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tglc_pkg::QCNT_W'(tglc_pkg::QUEUE_DEPTH))
    else $error("job queue over capacity");

  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o))
    else $error("job written into a full queue");

endmodule
`default_nettype wire

// ===== rtl/core/tglc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tglc_front: layout front end
// Accept beats, keep the pen, classify characters and issue glyph jobs.
// ----------------------------------------------------------------------------
module tglc_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [11:0] origin_x_i,
  input  wire logic [11:0] origin_y_i,
  input  wire logic [1:0]  anchor_i,
  input  wire logic [7:0]  text_length_i,
  output logic             job_wr_o,
  output tglc_pkg::job_t   job_o
);

  logic signed [15:0] pen_x_q, pen_x_d;
  logic signed [15:0] pen_y_q, pen_y_d;
  logic [11:0]        line_start_x_q, line_start_x_d;

  logic [16:0]        span;
  logic signed [17:0] start_x;
  logic signed [17:0] adv_x;
  logic signed [17:0] nl_y;
  logic [6:0]         glyph_idx;
  logic [12:0]        row_prod;
  logic [2:0]         row;
  logic [6:0]         col_full;
  logic               is_glyph;

  assign span = 17'(tglc_pkg::GLYPH_W) * (17'(text_length_i) + 17'd1);

  always_comb begin
    unique case (tglc_pkg::anchor_e'(anchor_i))
      tglc_pkg::ANCHOR_CENTRE: start_x = $signed({6'd0, origin_x_i})
                                       - $signed({2'b0, span[16:1]});
      tglc_pkg::ANCHOR_RIGHT:  start_x = $signed({6'd0, origin_x_i})
                                       - $signed({1'b0, span});
      default:                 start_x = $signed({6'd0, origin_x_i});
    endcase
  end

  assign adv_x = 18'(pen_x_q) + 18'(tglc_pkg::GLYPH_W + tglc_pkg::CHAR_GAP);
  assign nl_y  = 18'(pen_y_q) + 18'(tglc_pkg::GLYPH_H + tglc_pkg::LINE_GAP);

  // Atlas cell: row by reciprocal multiply, column as the remainder
  assign glyph_idx = 7'(char_code_i - tglc_pkg::CHAR_FIRST_GLYPH);
  assign row_prod  = 13'(glyph_idx) * 13'(tglc_pkg::ROW_RECIP);
  assign row       = row_prod[tglc_pkg::ROW_SHIFT +: 3];
  assign col_full  = glyph_idx - 7'(row) * 7'(tglc_pkg::ATLAS_COLS);
  assign is_glyph  = (char_code_i >= tglc_pkg::CHAR_FIRST_GLYPH)
                  && (char_code_i <= tglc_pkg::CHAR_LAST_GLYPH);

  always_comb begin
    pen_x_d        = pen_x_q;
    pen_y_d        = pen_y_q;
    line_start_x_d = line_start_x_q;
    job_wr_o       = 1'b0;
    job_o.pen_x    = pen_x_q;
    job_o.pen_y    = pen_y_q;
    job_o.col      = col_full[3:0];
    job_o.row      = row;
    if (accept_i) begin
      if (tglc_pkg::kind_e'(kind_i) == tglc_pkg::KIND_START) begin
        pen_x_d        = tglc_pkg::sat16(start_x);
        pen_y_d        = tglc_pkg::sat16($signed({6'd0, origin_y_i}));
        line_start_x_d = origin_x_i;
      end else if (char_code_i == tglc_pkg::CHAR_SPACE
                || char_code_i == tglc_pkg::CHAR_TAB) begin
        pen_x_d = tglc_pkg::sat16(adv_x);
      end else if (char_code_i == tglc_pkg::CHAR_NEWLINE) begin
        pen_x_d = tglc_pkg::sat16($signed({6'd0, line_start_x_q}));
        pen_y_d = tglc_pkg::sat16(nl_y);
      end else if (is_glyph) begin
        job_wr_o = 1'b1;
        pen_x_d  = tglc_pkg::sat16(adv_x);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q        <= '0;
      pen_y_q        <= '0;
      line_start_x_q <= '0;
    end else begin
      pen_x_q        <= pen_x_d;
      pen_y_q        <= pen_y_d;
      line_start_x_q <= line_start_x_d;
    end
  end

  a_start_sets_pen_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (kind_i == tglc_pkg::KIND_START)
      |=> pen_y_q == $signed({4'd0, $past(origin_y_i)}) && line_start_x_q == $past(origin_x_i))
    else $error("start beat did not load pen");

endmodule
`default_nettype wire

// ===== rtl/core/tglc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tglc_back: clip back end
// Hold clip registers, intersect each glyph job with the clip rectangle and
// register the surviving quad for the result side.
// ----------------------------------------------------------------------------
module tglc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [12:0]    cfg_data_i,
  input  wire logic           job_empty_i,
  input  wire tglc_pkg::job_t job_i,
  output logic                job_rd_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [11:0]         quad_x_o,
  output logic [11:0]         quad_y_o,
  output logic [7:0]          quad_w_o,
  output logic [7:0]          quad_h_o,
  output logic [11:0]         texel_x_o,
  output logic [11:0]         texel_y_o
);

  logic [11:0] clip_left_q, clip_top_q;
  logic [12:0] clip_width_q, clip_height_q;

  logic        out_valid_q, out_valid_d;
  logic [11:0] quad_x_q, quad_y_q, texel_x_q, texel_y_q;
  logic [7:0]  quad_w_q, quad_h_q;

  logic signed [17:0] px, py, cl, ct, cr, cb, gr, gb;
  logic signed [17:0] left, top, right, bottom, w, h;
  logic [13:0]        tx, ty;
  logic               emit, take;

  // Intersect the glyph rectangle with the clip rectangle
  assign px = 18'(job_i.pen_x);
  assign py = 18'(job_i.pen_y);
  assign cl = $signed({6'd0, clip_left_q});
  assign ct = $signed({6'd0, clip_top_q});
  assign cr = cl + $signed({5'd0, clip_width_q});
  assign cb = ct + $signed({5'd0, clip_height_q});
  assign gr = px + 18'(tglc_pkg::GLYPH_W);
  assign gb = py + 18'(tglc_pkg::GLYPH_H);

  assign left   = (px > cl) ? px : cl;
  assign top    = (py > ct) ? py : ct;
  assign right  = (gr < cr) ? gr : cr;
  assign bottom = (gb < cb) ? gb : cb;
  assign w      = right - left;
  assign h      = bottom - top;
  assign emit   = (w > 18'sd0) && (h > 18'sd0);

  assign tx = 14'(tglc_pkg::ATLAS_ORIGIN_X) + 14'(job_i.col) * 14'(tglc_pkg::GLYPH_W)
            + 14'(left - px);
  assign ty = 14'(job_i.row) * 14'(tglc_pkg::GLYPH_H) + 14'(top - py);

  // Take a job whenever the output register is free or being drained
  assign take     = !job_empty_i && (!out_valid_q || pop_i);
  assign job_rd_o = take;
  assign out_valid_d = take ? emit : (out_valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_width_q  <= 13'd4096;
      clip_height_q <= 13'd4096;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (tglc_pkg::reg_idx_e'(cfg_idx_i))
          tglc_pkg::REG_CLIP_LEFT:   clip_left_q   <= cfg_data_i[11:0];
          tglc_pkg::REG_CLIP_TOP:    clip_top_q    <= cfg_data_i[11:0];
          tglc_pkg::REG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i;
          tglc_pkg::REG_CLIP_HEIGHT: clip_height_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      quad_x_q  <= left[11:0];
      quad_y_q  <= top[11:0];
      quad_w_q  <= w[7:0];
      quad_h_q  <= h[7:0];
      texel_x_q <= tx[11:0];
      texel_y_q <= ty[11:0];
    end
  end

  assign empty_o   = !out_valid_q;
  assign quad_x_o  = quad_x_q;
  assign quad_y_o  = quad_y_q;
  assign quad_w_o  = quad_w_q;
  assign quad_h_o  = quad_h_q;
  assign texel_x_o = texel_x_q;
  assign texel_y_o = texel_y_q;

  a_quad_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (quad_w_q != 8'd0) && (quad_h_q != 8'd0))
    else $error("empty quad presented");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(quad_x_q) && $stable(texel_x_q))
    else $error("waiting result lost or changed");

endmodule
`default_nettype wire

// ===== rtl/core/text_glyph_layout_clip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted glyph beat enters the job queue, then its clipped quad is
// registered for the result side once that register is free or being popped.
// Throughput: one beat per cycle while results are popped; a waiting result
// lets two glyph jobs queue, then full holds every beat until the pop.
// Reset: asynchronous, active low; pen and line start clear to zero, clip
// rectangle returns to 0, 0, 4096, 4096, and queue and result side empty.
// ----------------------------------------------------------------------------
// text_glyph_layout_clip: text layout into clipped glyph quads
// Front end tracks the pen and turns printable characters into glyph jobs;
// back end clips each job against the clip rectangle and presents each surviving quad.
// ----------------------------------------------------------------------------
module text_glyph_layout_clip (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,
  // input side
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [11:0] origin_x_i,
  input  wire logic [11:0] origin_y_i,
  input  wire logic [1:0]  anchor_i,
  input  wire logic [7:0]  text_length_i,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic [11:0]      quad_x_o,
  output logic [11:0]      quad_y_o,
  output logic [7:0]       quad_w_o,
  output logic [7:0]       quad_h_o,
  output logic [11:0]      texel_x_o,
  output logic [11:0]      texel_y_o
);

  logic           accept;
  logic           job_wr, job_rd, job_full, job_empty;
  tglc_pkg::job_t job_in, job_out;

  // A beat is taken whenever the job queue has room; beats that move only
  // the pen never enter the queue.
  assign full   = job_full;
  assign accept = push && !job_full;

  tglc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .anchor_i      (anchor_i),
    .text_length_i (text_length_i),
    .job_wr_o      (job_wr),
    .job_o         (job_in)
  );

  // Decouple pen tracking from clipping
  tglc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_wr),
    .wr_job_i (job_in),
    .full_o   (job_full),
    .rd_i     (job_rd),
    .rd_job_o (job_out),
    .empty_o  (job_empty)
  );

  // Clip and hold the result beat until popped
  tglc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_rd_o    (job_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .quad_x_o    (quad_x_o),
    .quad_y_o    (quad_y_o),
    .quad_w_o    (quad_w_o),
    .quad_h_o    (quad_h_o),
    .texel_x_o   (texel_x_o),
    .texel_y_o   (texel_y_o)
  );

endmodule
`default_nettype wire
